// ----- rtl/gntd_pkg.sv -----
// shared constants, types and helpers of the grid nearest target distance unit
`timescale 1ns / 1ps
package gntd_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ADDR_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int DIM_W  = 7;
  localparam int DIST_W = 7;
  localparam int KIND_W = 2;
  localparam int LIN_W  = ROW_W + DIM_W + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SOURCE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TARGET = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef logic [KIND_W-1:0] kind_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] hops;
  } q_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    kind_t             wdata;
    logic [ADDR_W-1:0] raddr;
  } cell_req_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    q_entry_t          wdata;
    logic [ADDR_W-1:0] raddr;
  } q_req_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/gntd_in_if.sv -----
// cell input channel
`timescale 1ns / 1ps
interface gntd_in_if;
  logic                       valid;
  logic                       ready;
  logic [gntd_pkg::KIND_W-1:0] cell_kind;
  logic                       last_cell;

  modport source(output valid, output cell_kind, output last_cell, input ready);
  modport sink(input valid, input cell_kind, input last_cell, output ready);
endinterface

// ----- rtl/gntd_out_if.sv -----
// result output channel
`timescale 1ns / 1ps
interface gntd_out_if;
  logic                       valid;
  logic                       ready;
  logic [gntd_pkg::DIST_W-1:0] distance;
  logic                       found;

  modport source(output valid, output distance, output found, input ready);
  modport sink(input valid, input distance, input found, output ready);
endinterface

// ----- rtl/gntd_cell_mem.sv -----
// grid cell memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module gntd_cell_mem (
  input  logic                clk,
  input  gntd_pkg::cell_req_t req,
  output gntd_pkg::kind_t     rdata
);

  gntd_pkg::kind_t mem [gntd_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- rtl/gntd_queue_mem.sv -----
// frontier queue memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module gntd_queue_mem (
  input  logic               clk,
  input  gntd_pkg::q_req_t   req,
  output gntd_pkg::q_entry_t rdata
);

  gntd_pkg::q_entry_t mem [gntd_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ----- rtl/gntd_ctrl.sv -----
// load, fill, source scan and search sequencer with config registers
`timescale 1ns / 1ps
module gntd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [gntd_pkg::DIM_W-1:0]    cfg_data,
  gntd_in_if.sink                       cell_in,
  gntd_out_if.source                    result_out,
  output gntd_pkg::cell_req_t           cell_req,
  input  gntd_pkg::kind_t               cell_rdata,
  output gntd_pkg::q_req_t              q_req,
  input  gntd_pkg::q_entry_t            q_rdata
);

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_FILL  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_POP   = 8'b0000_1000,
    ST_FETCH = 8'b0001_0000,
    ST_NBR   = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [gntd_pkg::DIM_W-1:0]  rows;
  logic [gntd_pkg::DIM_W-1:0]  cols;
  logic [gntd_pkg::CNT_W-1:0]  load_pos;
  logic [gntd_pkg::CNT_W-1:0]  head;
  logic [gntd_pkg::CNT_W-1:0]  tail;
  logic [gntd_pkg::CNT_W-1:0]  scan_idx;
  logic [gntd_pkg::ROW_W-1:0]  scan_r;
  logic [gntd_pkg::COL_W-1:0]  scan_c;
  logic                        sv;
  logic [gntd_pkg::ROW_W-1:0]  sr;
  logic [gntd_pkg::COL_W-1:0]  sc;
  gntd_pkg::q_entry_t          cur;
  logic [1:0]                  k;
  logic                        pend_v;
  logic [gntd_pkg::ROW_W-1:0]  pend_r;
  logic [gntd_pkg::COL_W-1:0]  pend_c;
  logic [gntd_pkg::ADDR_W-1:0] pend_addr;
  logic                        res_found;
  logic [gntd_pkg::DIST_W-1:0] res_dist;
  logic                        out_valid;
  logic                        out_found;
  logic [gntd_pkg::DIST_W-1:0] out_dist;

  logic [gntd_pkg::DIM_W-1:0]  nr;
  logic [gntd_pkg::DIM_W-1:0]  nc;
  logic [gntd_pkg::CNT_W-1:0]  total;
  logic                        accept;
  gntd_pkg::kind_t             kind_in;
  logic                        nb_ok;
  logic [gntd_pkg::ROW_W-1:0]  nb_r;
  logic [gntd_pkg::COL_W-1:0]  nb_c;
  logic [gntd_pkg::LIN_W-1:0]  nb_lin;
  logic                        hit;
  logic                        fresh;
  logic [gntd_pkg::DIST_W-1:0] next_d;
  logic                        scan_hit;
  logic                        processing;

  assign nr    = gntd_pkg::eff_dim(rows, gntd_pkg::DIM_W'(gntd_pkg::MAX_ROWS));
  assign nc    = gntd_pkg::eff_dim(cols, gntd_pkg::DIM_W'(gntd_pkg::MAX_COLS));
  assign total = gntd_pkg::CNT_W'(nr) * gntd_pkg::CNT_W'(nc);

  assign cell_in.ready = (state == ST_LOAD);
  assign accept        = cell_in.valid && cell_in.ready;
  assign kind_in       = (cell_in.cell_kind == gntd_pkg::KIND_SOURCE ||
                          cell_in.cell_kind == gntd_pkg::KIND_TARGET)
                         ? cell_in.cell_kind : gntd_pkg::KIND_OPEN;

  assign result_out.valid    = out_valid;
  assign result_out.distance = out_dist;
  assign result_out.found    = out_found;

  // neighbor order: left, up, right, down
  always_comb begin
    nb_r  = cur.row;
    nb_c  = cur.col;
    nb_ok = 1'b0;
    unique case (k)
      2'd0: begin
        nb_ok = (cur.col != '0);
        nb_c  = cur.col - gntd_pkg::COL_W'(1);
      end
      2'd1: begin
        nb_ok = (cur.row != '0);
        nb_r  = cur.row - gntd_pkg::ROW_W'(1);
      end
      2'd2: begin
        nb_ok = (gntd_pkg::DIM_W'(cur.col) + gntd_pkg::DIM_W'(1)) < nc;
        nb_c  = cur.col + gntd_pkg::COL_W'(1);
      end
      default: begin
        nb_ok = (gntd_pkg::DIM_W'(cur.row) + gntd_pkg::DIM_W'(1)) < nr;
        nb_r  = cur.row + gntd_pkg::ROW_W'(1);
      end
    endcase
  end

  assign nb_lin = gntd_pkg::LIN_W'(nb_r) * gntd_pkg::LIN_W'(nc) + gntd_pkg::LIN_W'(nb_c);

  assign processing = pend_v && (state == ST_NBR || state == ST_DRAIN);
  assign hit        = processing && (cell_rdata == gntd_pkg::KIND_TARGET);
  assign fresh      = processing && (cell_rdata != gntd_pkg::KIND_TARGET) &&
                      (cell_rdata != gntd_pkg::KIND_SOURCE);
  assign next_d     = (cur.hops == gntd_pkg::DIST_MAX) ? cur.hops
                      : cur.hops + gntd_pkg::DIST_W'(1);
  assign scan_hit   = (state == ST_SCAN) && sv && (cell_rdata == gntd_pkg::KIND_SOURCE);

  always_comb begin
    cell_req.we    = 1'b0;
    cell_req.waddr = load_pos[gntd_pkg::ADDR_W-1:0];
    cell_req.wdata = gntd_pkg::KIND_OPEN;
    cell_req.raddr = (state == ST_SCAN) ? scan_idx[gntd_pkg::ADDR_W-1:0]
                     : nb_lin[gntd_pkg::ADDR_W-1:0];
    if (state == ST_LOAD) begin
      cell_req.we    = accept && (load_pos < total);
      cell_req.wdata = kind_in;
    end else if (state == ST_FILL) begin
      cell_req.we = (load_pos < total);
    end else if (fresh) begin
      cell_req.we    = 1'b1;
      cell_req.waddr = pend_addr;
      cell_req.wdata = gntd_pkg::KIND_SOURCE;
    end
  end

  always_comb begin
    q_req.we    = scan_hit || fresh;
    q_req.waddr = tail[gntd_pkg::ADDR_W-1:0];
    q_req.raddr = head[gntd_pkg::ADDR_W-1:0];
    if (scan_hit) begin
      q_req.wdata = '{row: sr, col: sc, hops: '0};
    end else begin
      q_req.wdata = '{row: pend_r, col: pend_c, hops: next_d};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows      <= gntd_pkg::DIM_W'(1);
      cols      <= gntd_pkg::DIM_W'(1);
      state     <= ST_LOAD;
      load_pos  <= '0;
      head      <= '0;
      tail      <= '0;
      scan_idx  <= '0;
      sv        <= 1'b0;
      pend_v    <= 1'b0;
      k         <= '0;
      out_valid <= 1'b0;
      res_found <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == gntd_pkg::REG_ROWS) begin
          rows <= cfg_data;
        end else begin
          cols <= cfg_data;
        end
      end
      if (result_out.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      if (q_req.we) begin
        tail <= tail + gntd_pkg::CNT_W'(1);
      end
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (load_pos < total) begin
              load_pos <= load_pos + gntd_pkg::CNT_W'(1);
            end
            if (cell_in.last_cell) begin
              state <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          if (load_pos < total) begin
            load_pos <= load_pos + gntd_pkg::CNT_W'(1);
          end else begin
            load_pos <= '0;
            scan_idx <= '0;
            scan_r   <= '0;
            scan_c   <= '0;
            sv       <= 1'b0;
            head     <= '0;
            tail     <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          sv <= (scan_idx < total);
          sr <= scan_r;
          sc <= scan_c;
          if (scan_idx < total) begin
            scan_idx <= scan_idx + gntd_pkg::CNT_W'(1);
            if ((gntd_pkg::DIM_W'(scan_c) + gntd_pkg::DIM_W'(1)) == nc) begin
              scan_c <= '0;
              scan_r <= scan_r + gntd_pkg::ROW_W'(1);
            end else begin
              scan_c <= scan_c + gntd_pkg::COL_W'(1);
            end
          end else if (!sv) begin
            state <= ST_POP;
          end
        end
        ST_POP: begin
          if (head == tail) begin
            res_found <= 1'b0;
            res_dist  <= '0;
            state     <= ST_DONE;
          end else begin
            head  <= head + gntd_pkg::CNT_W'(1);
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          cur    <= q_rdata;
          k      <= '0;
          pend_v <= 1'b0;
          state  <= ST_NBR;
        end
        ST_NBR: begin
          pend_v    <= nb_ok;
          pend_r    <= nb_r;
          pend_c    <= nb_c;
          pend_addr <= nb_lin[gntd_pkg::ADDR_W-1:0];
          k         <= k + 2'd1;
          if (hit) begin
            res_found <= 1'b1;
            res_dist  <= next_d;
            state     <= ST_DONE;
          end else if (k == 2'd3) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend_v <= 1'b0;
          if (hit) begin
            res_found <= 1'b1;
            res_dist  <= next_d;
            state     <= ST_DONE;
          end else begin
            state <= ST_POP;
          end
        end
        ST_DONE: begin
          if (!out_valid || result_out.ready) begin
            out_valid <= 1'b1;
            out_found <= res_found;
            out_dist  <= res_dist;
            state     <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/grid_nearest_target_distance_unit.sv -----
// top level of the grid nearest target distance unit
`timescale 1ns / 1ps
// Cells are taken one beat per cycle while loading, in row-major order over rows x cols
// (registers 0 and 1, 0 acts as 1, values above 64 act as 64). A beat with last_cell
// closes the grid; the unit then stops taking cells until its result is registered.
// After the last cell it marks the cells not loaded as open, scans the cell memory for
// sources, and then works through each cell taken from the frontier queue in steps: one
// queue read, four neighbor reads of the cell memory issued back to back with the check
// and write-back of each read in the cycle after it, and a drain step. The single read
// port of the cell memory is why the neighbor reads go one at a time. The search stops at
// the first target reached; a held result does not block the loading of the next grid.
module grid_nearest_target_distance_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [gntd_pkg::DIM_W-1:0] cfg_data,
  gntd_in_if.sink                    cell_in,
  gntd_out_if.source                 result_out
);

  gntd_pkg::cell_req_t cell_req;
  gntd_pkg::kind_t     cell_rdata;
  gntd_pkg::q_req_t    q_req;
  gntd_pkg::q_entry_t  q_rdata;

  gntd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_in    (cell_in),
    .result_out (result_out),
    .cell_req   (cell_req),
    .cell_rdata (cell_rdata),
    .q_req      (q_req),
    .q_rdata    (q_rdata)
  );

  gntd_cell_mem u_cell_mem (
    .clk   (clk),
    .req   (cell_req),
    .rdata (cell_rdata)
  );

  gntd_queue_mem u_queue_mem (
    .clk   (clk),
    .req   (q_req),
    .rdata (q_rdata)
  );

endmodule

// ----- verif/tb.sv -----
// testbench for the grid nearest target distance unit
`timescale 1ns / 1ps
module tb;
  import gntd_pkg::*;

  localparam kind_t KIND_UNUSED   = 2'd3;
  localparam int    STALL_LIMIT   = 200000;
  localparam int    SETTLE_CYCLES = 20;
  localparam int    TAIL_CYCLES   = 50;
  localparam int    HOLD_CYCLES   = 600;
  localparam int    ITEM_BUDGET   = 1400;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              found;
  } result_t;

  class distance_scoreboard;
    kind_t            grid [CELL_COUNT];
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    int               load_pos;
    result_t          pending_results [$];
    int               errors;
    int               checked;
    int               hits;
    int               max_dist;

    function new();
      rows_reg = DIM_W'(1);
      cols_reg = DIM_W'(1);
      load_pos = 0;
      errors   = 0;
      checked  = 0;
      hits     = 0;
      max_dist = 0;
    endfunction

    function void write_reg(logic index, logic [DIM_W-1:0] value);
      if (index == REG_ROWS) begin
        rows_reg = value;
      end else begin
        cols_reg = value;
      end
    endfunction

    function int clamp_dim(logic [DIM_W-1:0] v, int limit);
      if (v == 0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
    endfunction

    function int cells_in_grid();
      return clamp_dim(rows_reg, MAX_ROWS) * clamp_dim(cols_reg, MAX_COLS);
    endfunction

    // multi-source breadth-first search, stops at the first target reached
    function result_t nearest_target(int nr, int nc);
      int      frontier [$];
      int      steps [$];
      int      idx;
      int      d;
      int      r;
      int      c;
      int      rr;
      int      cc;
      int      n;
      result_t res;
      res = '0;
      for (int i = 0; i < nr * nc; i++) begin
        if (grid[i] == KIND_SOURCE) begin
          frontier.insert(frontier.size(), i);
          steps.insert(steps.size(), 0);
        end
      end
      while (frontier.size() > 0 && !res.found) begin
        idx = frontier.pop_front();
        d   = steps.pop_front();
        r   = idx / nc;
        c   = idx % nc;
        for (int k = 0; k < 4; k++) begin
          rr = r;
          cc = c;
          case (k)
            0: cc = c - 1;
            1: rr = r - 1;
            2: cc = c + 1;
            default: rr = r + 1;
          endcase
          if (res.found || rr < 0 || cc < 0 || rr >= nr || cc >= nc) continue;
          n = rr * nc + cc;
          if (grid[n] == KIND_SOURCE) continue;
          if (grid[n] == KIND_TARGET) begin
            res.found    = 1'b1;
            res.distance = (d + 1 > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(d + 1);
          end else begin
            grid[n] = KIND_SOURCE;
            frontier.insert(frontier.size(), n);
            steps.insert(steps.size(), d + 1);
          end
        end
      end
      return res;
    endfunction

    function void note_cell(kind_t kind, logic last);
      int total;
      total = cells_in_grid();
      if (load_pos < total) begin
        grid[load_pos] = (kind == KIND_UNUSED) ? KIND_OPEN : kind;
        load_pos++;
      end
      if (last) begin
        // cells never loaded count as open
        while (load_pos < total) begin
          grid[load_pos] = KIND_OPEN;
          load_pos++;
        end
        pending_results.insert(pending_results.size(),
                               nearest_target(clamp_dim(rows_reg, MAX_ROWS),
                                              clamp_dim(cols_reg, MAX_COLS)));
        load_pos = 0;
      end
    endfunction

    function void check_result(logic [DIST_W-1:0] distance, logic found);
      result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: distance %0d found %0b",
                 $time, distance, found);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (want.distance !== distance) begin
        errors++;
        $display("%0t: distance mismatch: expected %0d actual %0d",
                 $time, want.distance, distance);
      end
      if (want.found !== found) begin
        errors++;
        $display("%0t: found mismatch: expected %0b actual %0b", $time, want.found, found);
      end
      if (want.found) begin
        hits++;
        if (int'(want.distance) > max_dist) max_dist = int'(want.distance);
      end
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [DIM_W-1:0] cfg_data;

  gntd_in_if  cell_in ();
  gntd_out_if result_out ();

  grid_nearest_target_distance_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_in    (cell_in),
    .result_out (result_out)
  );

  distance_scoreboard sb;
  int items_sent    = 0;
  int grids_sent    = 0;
  int size_settings = 0;
  int burst_left    = 0;
  int holds_asked   = 0;
  int idle_cycles   = 0;
  bit long_hold     = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      sb.check_result(result_out.distance, result_out.found);
    end
  end

  always @(posedge clk) begin
    if (rst || (cell_in.valid && cell_in.ready) || (result_out.valid && result_out.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : receiver
    int mode;
    int span;
    result_out.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        result_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        case (mode)
          0: result_out.ready <= 1'b1;
          1: result_out.ready <= 1'($urandom_range(0, 1));
          2: result_out.ready <= ($urandom_range(0, 3) == 0);
          default: result_out.ready <= !result_out.ready;
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic set_grid_size(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    sb.write_reg(REG_ROWS, r);
    cfg_index <= REG_COLS;
    cfg_data  <= c;
    @(posedge clk);
    sb.write_reg(REG_COLS, c);
    cfg_we <= 1'b0;
    size_settings++;
  endtask

  task automatic send_cell(input kind_t kind, input logic last);
    cell_in.valid     <= 1'b1;
    cell_in.cell_kind <= kind;
    cell_in.last_cell <= last;
    do @(posedge clk); while (cell_in.ready !== 1'b1);
    sb.note_cell(kind, last);
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    cell_in.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic load_grid(input kind_t cells [$], input bit paced);
    int gap;
    foreach (cells[i]) begin
      if (paced && burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) pause_sender(gap);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(1, 12);
      end
      if (holds_asked < 2 && items_sent >= 400 + 500 * holds_asked) begin
        long_hold = 1'b1;
        holds_asked++;
      end
      send_cell(cells[i], i == cells.size() - 1);
      if (burst_left > 0) burst_left--;
    end
    grids_sent++;
  endtask

  task automatic wait_for_results();
    cell_in.valid <= 1'b0;
    while (sb.pending_count() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic kind_t random_kind();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return KIND_SOURCE;
    if (pick < 16) return KIND_TARGET;
    if (pick < 19) return KIND_UNUSED;
    return KIND_OPEN;
  endfunction

  function automatic logic [DIM_W-1:0] odd_dim();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return DIM_W'($urandom_range(65, 127));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin : stimulus
    kind_t            cells [$];
    int               flavor;
    int               ngrids;
    int               total;
    int               len;
    int               shape;
    int               span;
    logic [DIM_W-1:0] r;
    logic [DIM_W-1:0] c;
    sb = new();
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_ROWS;
    cfg_data          <= '0;
    cell_in.valid     <= 1'b0;
    cell_in.cell_kind <= KIND_OPEN;
    cell_in.last_cell <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero sizes act as one, a lone source finds nothing
    set_grid_size('0, '0);
    cells = '{KIND_SOURCE};
    load_grid(cells, 0);
    wait_for_results();

    set_grid_size(DIM_W'(1), DIM_W'(2));
    cells = '{KIND_SOURCE, KIND_TARGET};
    load_grid(cells, 0);
    cells = '{KIND_TARGET, KIND_SOURCE};
    load_grid(cells, 0);
    cells = '{KIND_UNUSED, KIND_TARGET};
    load_grid(cells, 0);
    wait_for_results();

    // full grid, too many cells, early last cell
    set_grid_size(DIM_W'(2), DIM_W'(2));
    cells = '{KIND_SOURCE, KIND_OPEN, KIND_OPEN, KIND_TARGET};
    load_grid(cells, 0);
    cells = '{KIND_OPEN, KIND_OPEN, KIND_OPEN, KIND_SOURCE, KIND_TARGET, KIND_TARGET};
    load_grid(cells, 0);
    cells = '{KIND_TARGET, KIND_SOURCE};
    load_grid(cells, 0);
    wait_for_results();

    // oversize rows clamp to the maximum
    set_grid_size(DIM_W'(127), DIM_W'(64));
    cells = '{KIND_SOURCE, KIND_OPEN, KIND_TARGET};
    load_grid(cells, 0);
    wait_for_results();

    while (items_sent < ITEM_BUDGET) begin
      flavor = $urandom_range(0, 9);
      if (flavor <= 5) begin
        r = DIM_W'($urandom_range(1, 8));
        c = DIM_W'($urandom_range(1, 8));
        ngrids = $urandom_range(2, 6);
      end else if (flavor <= 7) begin
        r = DIM_W'($urandom_range(1, 20));
        c = DIM_W'($urandom_range(1, 20));
        ngrids = $urandom_range(1, 3);
      end else if (flavor == 8) begin
        r = DIM_W'($urandom_range(1, 127));
        c = DIM_W'($urandom_range(1, 127));
        ngrids = 1;
      end else begin
        r = odd_dim();
        c = odd_dim();
        ngrids = $urandom_range(1, 3);
      end
      set_grid_size(r, c);
      total = sb.cells_in_grid();
      repeat (ngrids) begin
        shape = $urandom_range(0, 99);
        if (flavor == 8) begin
          len = $urandom_range(1, (total < 48) ? total : 48);
        end else if (shape < 70) begin
          len = total;
        end else if (shape < 85) begin
          len = $urandom_range(1, total);
        end else begin
          len = total + $urandom_range(1, 5);
        end
        cells.delete();
        repeat (len) cells.insert(cells.size(), random_kind());
        span = (len < total) ? len : total;
        if ($urandom_range(0, 99) < 60) begin
          cells[$urandom_range(0, span - 1)] = KIND_SOURCE;
          cells[$urandom_range(0, span - 1)] = KIND_TARGET;
        end
        load_grid(cells, 1);
      end
      // sender waits for every result before the size changes
      wait_for_results();
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d cells in %0d grids over %0d size settings, out of range sizes included",
             items_sent, grids_sent, size_settings);
    $display("checked %0d results, %0d with a reachable target, longest distance %0d",
             sb.checked, sb.hits, sb.max_dist);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
